### rtl/mbe_pkg.sv
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 8;

  // palette constants
  localparam logic [7:0] PAL_FULL  = 8'hff;
  localparam logic [7:0] PAL_BLACK = 8'h00;
  localparam logic [7:0] PAL_HALF  = 8'd128;

  // fractal_mode codes
  localparam logic MODE_MANDEL = 1'b0;
  localparam logic MODE_SHIP   = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RR   = 6'b000010,
    S_II   = 6'b000100,
    S_RI   = 6'b001000,
    S_UPD  = 6'b010000,
    S_FIN  = 6'b100000
  } mbe_state_t;

  // request to the shared multiplier
  typedef struct packed {
    logic                     en;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } mbe_mul_req_t;

endpackage

### rtl/mbe_fxmul.sv
`timescale 1ns / 1ps

module mbe_fxmul #(
  parameter int FRACTION_BITS = 28
) (
  input  logic                                clk,
  input  mbe_pkg::mbe_mul_req_t               req,
  output logic signed [mbe_pkg::WORD_W-1:0]   prod_r
);
  import mbe_pkg::*;

  logic signed [2*WORD_W-1:0] full;
  logic signed [WORD_W-1:0]   prod_nxt;

  // exact signed product, keep the scaled 32-bit window (floor, wrapped)
  assign full     = req.a * req.b;
  assign prod_nxt = full[FRACTION_BITS+WORD_W-1:FRACTION_BITS];

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### rtl/mbe_palette.sv
`timescale 1ns / 1ps

module mbe_palette #(
  parameter int ITER_LIMIT = 255
) (
  input  logic [mbe_pkg::CNT_W-1:0] count,
  input  logic                      mode,
  output logic [7:0]                red,
  output logic [7:0]                blue
);
  import mbe_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(ITER_LIMIT);

  always_comb begin
    red  = PAL_BLACK;
    blue = PAL_BLACK;
    if (count != '0 && count != LIMIT_CNT) begin
      if (mode == MODE_SHIP) begin
        red = {count[6:0], 1'b0} + PAL_FULL;
      end else if (count < PAL_HALF) begin
        red  = {count[4:0], 3'b000} + PAL_FULL;
        blue = {count[3:0], 4'b0000} + PAL_FULL;
      end else begin
        blue = PAL_FULL - {count[6:0], 1'b0};
      end
    end
  end

endmodule

### rtl/mandelbrot_escape_iteration.sv
`timescale 1ns / 1ps
// sequencing: each iteration steps S_RR, S_II, S_RI, S_UPD through one shared 32x32
//   multiplier; an item runs n iterations (n = escape index + 1, or ITER_LIMIT),
//   then waits in S_FIN for a free output slot before out_valid rises
// flow: one item at a time; the next item is accepted in S_IDLE once the result
//   is parked in the output registers
// reset: synchronous active-low rst_n clears the sequencer, out_valid and the mode register
module mandelbrot_escape_iteration #(
  parameter int FRACTION_BITS = 28,
  parameter int ITER_LIMIT    = 255
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // point input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [mbe_pkg::WORD_W-1:0] in_c_real,
  input  logic signed [mbe_pkg::WORD_W-1:0] in_c_imag,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mbe_pkg::CNT_W-1:0]         out_iter_count,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_blue,
  // mode register
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_wdata
);
  import mbe_pkg::*;

  // escape threshold 4.0 in wider arithmetic; the square sum is sign-extended
  // to the same width before the compare
  localparam logic signed [WORD_W+1:0] ESC_LIMIT =
    (WORD_W+2)'(4) <<< FRACTION_BITS;
  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(ITER_LIMIT);
  localparam logic [CNT_W-1:0] LAST_IT   = CNT_W'(ITER_LIMIT - 1);

  mbe_state_t state_r, state_nxt;

  logic                     mode_r;
  logic signed [WORD_W-1:0] cr_r, ci_r;
  logic signed [WORD_W-1:0] zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [WORD_W-1:0] rr_r, ii_r;
  logic [CNT_W-1:0]         it_r, it_nxt;

  logic                     out_valid_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic [7:0]               out_red_r, out_blue_r;

  mbe_mul_req_t             mul_req;
  logic signed [WORD_W-1:0] prod_r;

  logic signed [WORD_W-1:0] cross_term, cross_abs, sq_sum;
  logic                     escaped;
  logic                     out_free;
  logic [7:0]               pal_red, pal_blue;

  // one shared multiplier for zr*zr, zi*zi and zr*zi
  mbe_fxmul #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk   (clk),
    .req   (mul_req),
    .prod_r(prod_r)
  );

  mbe_palette #(
    .ITER_LIMIT(ITER_LIMIT)
  ) u_pal (
    .count(it_r),
    .mode (mode_r),
    .red  (pal_red),
    .blue (pal_blue)
  );

  // operand select for the multiplier, one product per state
  always_comb begin
    mul_req = '0;
    unique case (state_r)
      S_RR: begin
        mul_req.en = 1'b1;
        mul_req.a  = zr_r;
        mul_req.b  = zr_r;
      end
      S_II: begin
        mul_req.en = 1'b1;
        mul_req.a  = zi_r;
        mul_req.b  = zi_r;
      end
      S_RI: begin
        mul_req.en = 1'b1;
        mul_req.a  = zr_r;
        mul_req.b  = zi_r;
      end
      default: mul_req = '0;
    endcase
  end

  // update step: prod_r holds zr*zi here
  assign cross_term = {prod_r[WORD_W-2:0], 1'b0};
  assign cross_abs  = (mode_r == MODE_SHIP && cross_term[WORD_W-1]) ?
                      WORD_W'(0 - cross_term) : cross_term;
  assign sq_sum     = rr_r + ii_r;
  assign escaped    = $signed({{2{sq_sum[WORD_W-1]}}, sq_sum}) > ESC_LIMIT;
  assign out_free   = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    it_nxt    = it_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RR;
          zr_nxt    = '0;
          zi_nxt    = '0;
          it_nxt    = '0;
        end
      end
      S_RR:  state_nxt = S_II;
      S_II:  state_nxt = S_RI;
      S_RI:  state_nxt = S_UPD;
      S_UPD: begin
        zr_nxt = rr_r - ii_r + cr_r;
        zi_nxt = cross_abs + ci_r;
        if (escaped) begin
          state_nxt = S_FIN;          // it_r is the escape index
        end else if (it_r == LAST_IT) begin
          state_nxt = S_FIN;
          it_nxt    = LIMIT_CNT;      // never escaped
        end else begin
          state_nxt = S_RR;
          it_nxt    = it_r + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_MANDEL;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata[0];
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    zr_r <= zr_nxt;
    zi_r <= zi_nxt;
    it_r <= it_nxt;
    if (in_valid && in_ready) begin
      cr_r <= in_c_real;
      ci_r <= in_c_imag;
    end
    if (state_r == S_II) begin
      rr_r <= prod_r;
    end
    if (state_r == S_RI) begin
      ii_r <= prod_r;
    end
    if (state_r == S_FIN && out_free) begin
      out_cnt_r  <= it_r;
      out_red_r  <= pal_red;
      out_blue_r <= pal_blue;
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_iter_count = out_cnt_r;
  assign out_red        = out_red_r;
  assign out_blue       = out_blue_r;

  // an accepted point always starts with the first square
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_RR)
    else $error("accepted point did not start iterating");

  // the iteration index never runs past the limit
  a_it_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD || state_r == S_FIN |-> it_r <= LIMIT_CNT)
    else $error("iteration index beyond limit");

  // a finished point with a free output slot shows up next cycle
  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_free |=> out_valid_r)
    else $error("finished point not delivered");

  // escape at zero or no escape gives black
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_cnt_r == '0 || out_cnt_r == LIMIT_CNT)
      |-> out_red_r == PAL_BLACK && out_blue_r == PAL_BLACK)
    else $error("non-black color for interior point");

  // burning ship ramp has no blue
  a_ship_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mode_r == MODE_SHIP |-> out_blue_r == PAL_BLACK)
    else $error("blue set in burning ship mode");

endmodule

### verif/mbe_escape_checker.sv
`timescale 1ns / 1ps

module mbe_escape_checker #(
  parameter int FRACTION_BITS = 28,
  parameter int ITER_LIMIT    = 255
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [mbe_pkg::WORD_W-1:0]  in_c_real,
  input  logic [mbe_pkg::WORD_W-1:0]  in_c_imag,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [mbe_pkg::CNT_W-1:0]   out_iter_count,
  input  logic [7:0]                  out_red,
  input  logic [7:0]                  out_blue,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_wdata,
  output int                          fail_count,
  output int                          pending,
  output int                          n_checked,
  output int                          n_bounded
);
  import mbe_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] cr;
    logic [WORD_W-1:0] ci;
    logic [CNT_W-1:0]  iter;
    logic [7:0]        red;
    logic [7:0]        blue;
  } pixel_t;

  pixel_t expected_pixels[$];
  logic   fractal_mode;

  // floor(a*b / 2^FRACTION_BITS), wrapped to the word
  function automatic logic [WORD_W-1:0] fx_mul(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    longint prod;
    prod = longint'($signed(a)) * longint'($signed(b));
    return prod[FRACTION_BITS +: WORD_W];
  endfunction

  function automatic pixel_t predict_pixel(logic [WORD_W-1:0] cr, logic [WORD_W-1:0] ci,
                                           logic ship);
    logic [WORD_W-1:0] zr, zi, rr, ii, cross_term, sq_sum;
    longint            threshold;
    int                n;
    pixel_t            px;
    zr = '0;
    zi = '0;
    n = ITER_LIMIT;
    threshold = longint'(4) <<< FRACTION_BITS;
    for (int it = 0; it < ITER_LIMIT && n == ITER_LIMIT; it++) begin
      rr = fx_mul(zr, zr);
      ii = fx_mul(zi, zi);
      cross_term = fx_mul(zr, zi) << 1;
      sq_sum = rr + ii;
      // burning ship folds the cross term; the most negative word stays put
      if (ship && cross_term[WORD_W-1]) cross_term = '0 - cross_term;
      zr = rr - ii + cr;
      zi = cross_term + ci;
      if (longint'($signed(sq_sum)) > threshold) n = it;
    end
    px.cr = cr;
    px.ci = ci;
    px.iter = n[CNT_W-1:0];
    px.red = PAL_BLACK;
    px.blue = PAL_BLACK;
    if (n != 0 && n != ITER_LIMIT) begin
      if (ship) begin
        px.red = 8'(2 * n - 256 + 255);
      end else if (n < 128) begin
        px.red  = 8'(8 * n - 1024 + 255);
        px.blue = 8'(16 * n - 1024 + 255);
      end else begin
        px.blue = 8'(255 - 2 * (n - 128));
      end
    end
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    n_checked = 0;
    n_bounded = 0;
  end

  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst_n) begin
      fractal_mode <= MODE_MANDEL;
    end else begin
      if (cfg_we) fractal_mode <= cfg_wdata[0];
      if (in_valid && in_ready)
        expected_pixels.push_back(predict_pixel(in_c_real, in_c_imag,
                                                fractal_mode == MODE_SHIP));
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result iter %0d with no point outstanding",
                                    out_iter_count));
        end else begin
          exp_px = expected_pixels.pop_front();
          n_checked++;
          if (exp_px.iter == ITER_LIMIT) n_bounded++;
          if (out_iter_count !== exp_px.iter)
            report_mismatch($sformatf("c=(%h,%h) iter %0d, expected %0d",
                                      exp_px.cr, exp_px.ci, out_iter_count, exp_px.iter));
          if (out_red !== exp_px.red)
            report_mismatch($sformatf("c=(%h,%h) red %h, expected %h",
                                      exp_px.cr, exp_px.ci, out_red, exp_px.red));
          if (out_blue !== exp_px.blue)
            report_mismatch($sformatf("c=(%h,%h) blue %h, expected %h",
                                      exp_px.cr, exp_px.ci, out_blue, exp_px.blue));
        end
      end
    end
    pending <= expected_pixels.size();
  end

endmodule

### verif/tb_mandelbrot_escape_iteration.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_iteration;
  import mbe_pkg::*;

  localparam int FRACTION_BITS  = 28;
  localparam int ITER_LIMIT     = 255;
  // room for several of the slowest items plus stalls
  localparam int WATCHDOG_LIMIT = 5000;
  // drain after the last result, a bit over one worst-case item
  localparam int DRAIN_CYCLES   = 1100;
  localparam int PHASE_ITEMS    = 270;
  localparam int N_DIRECTED     = 13;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [WORD_W-1:0] in_c_real = '0;
  logic [WORD_W-1:0] in_c_imag = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CNT_W-1:0]  out_iter_count;
  logic [7:0]        out_red;
  logic [7:0]        out_blue;
  logic              cfg_we    = 1'b0;
  logic [0:0]        cfg_wdata = '0;

  int   mismatches;
  int   pending;
  int   n_checked;
  int   n_bounded;
  int   points_sent = 0;
  int   mode_writes = 0;
  int   idle_cycles = 0;
  // when set, neither side inserts bubbles
  logic no_idle     = 1'b0;

  always #5 clk = ~clk;

  mandelbrot_escape_iteration #(
    .FRACTION_BITS(FRACTION_BITS),
    .ITER_LIMIT   (ITER_LIMIT)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_c_real     (in_c_real),
    .in_c_imag     (in_c_imag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_iter_count(out_iter_count),
    .out_red       (out_red),
    .out_blue      (out_blue),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  mbe_escape_checker #(
    .FRACTION_BITS(FRACTION_BITS),
    .ITER_LIMIT   (ITER_LIMIT)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_c_real     (in_c_real),
    .in_c_imag     (in_c_imag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_iter_count(out_iter_count),
    .out_red       (out_red),
    .out_blue      (out_blue),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (mismatches),
    .pending       (pending),
    .n_checked     (n_checked),
    .n_bounded     (n_bounded)
  );

  // result side backpressure, roughly 29 stalled cycles in a hundred
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 29);
  end

  // watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d points outstanding",
                 idle_cycles, pending);
        $display("mandelbrot_escape_iteration regression: fail");
        $finish;
      end
    end
  end

  // offer one point, optionally after a random bubble, and hold until taken
  task automatic send_point(input logic [WORD_W-1:0] cr, input logic [WORD_W-1:0] ci);
    if (!no_idle && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_c_real <= cr;
    in_c_imag <= ci;
    do @(posedge clk); while (!(in_valid && in_ready));
    points_sent++;
  endtask

  // mode change only once the block has drained every point
  task automatic set_mode(input logic mode);
    in_valid <= 1'b0;
    // let the checker's pending count catch up with the point just taken
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_writes++;
    @(posedge clk);
  endtask

  initial begin
    logic [63:0] pt;
    logic [WORD_W-1:0] re, im;
    int sel;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, first with the reset mode, then burning ship
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) set_mode(MODE_SHIP);
      for (int k = 0; k < N_DIRECTED; k++) begin
        case (k)
          0:  pt = {32'h00000000, 32'h00000000};  // origin, never escapes
          1:  pt = {32'h80000000, 32'h80000000};  // most negative corner
          2:  pt = {32'h7fffffff, 32'h7fffffff};  // most positive corner
          3:  pt = {32'h80000000, 32'h7fffffff};
          // 2+2i: square sum wraps negative, cross term lands on the most negative word
          4:  pt = {32'h20000000, 32'h20000000};
          5:  pt = {32'h20000000, 32'he0000000};
          6:  pt = {32'he0000000, 32'h00000000};  // -2: square sum sits exactly on 4.0
          7:  pt = {32'h20000000, 32'h00000000};  // +2: stays on 4.0, never escapes
          8:  pt = {32'hffffffff, 32'hffffffff};  // tiny negatives, floor rounding
          9:  pt = {32'hf4000000, 32'h00cccccd};  // near the neck, mid count
          10: pt = {32'hf4000000, 32'h0051eb85};  // closer to the neck, high count
          11: pt = {32'h0428f5c3, 32'h00000000};  // just past the cusp
          default: pt = {32'h040068dc, 32'h00000000};  // hair past the cusp
        endcase
        send_point(pt[63:32], pt[31:0]);
      end
    end

    // random phases, alternating modes
    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase[0] ? MODE_SHIP : MODE_MANDEL);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // a long stretch with no bubbles on either side in the third phase
        if (phase == 2 && n == 60) no_idle <= 1'b1;
        if (phase == 2 && n == 220) no_idle <= 1'b0;
        sel = $urandom_range(99);
        if (sel < 65) begin
          // the interesting window, about [-2.5,1.5] x [-2,2]
          re = 32'hd8000000 + $urandom_range(0, 32'h40000000);
          im = 32'he0000000 + $urandom_range(0, 32'h40000000);
        end else if (sel < 75) begin
          // around the neck at -0.75, where counts run high
          re = 32'hf4000000 + $urandom_range(0, 32'h00200000) - 32'h00100000;
          im = $urandom_range(0, 32'h02000000) - 32'h01000000;
        end else begin
          // raw words over the whole range
          re = $urandom;
          im = $urandom;
        end
        send_point(re, im);
      end
    end
    in_valid <= 1'b0;

    // let every result arrive, then give stragglers time to show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d points over %0d mode writes, both fractals, corners and neck",
             points_sent, mode_writes);
    $display("%0d results checked, %0d never escaped, %0d mismatches",
             n_checked, n_bounded, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("mandelbrot_escape_iteration regression: pass");
    else
      $display("mandelbrot_escape_iteration regression: fail");
    $finish;
  end

endmodule

### mandelbrot_escape_iteration.f
rtl/mbe_pkg.sv
rtl/mbe_fxmul.sv
rtl/mbe_palette.sv
rtl/mandelbrot_escape_iteration.sv
verif/mbe_escape_checker.sv
verif/tb_mandelbrot_escape_iteration.sv
